// ===== design/mcl_wdog_pkg.sv =====
package mcl_wdog_pkg;

    // Duty path width; commands are clamped to this many bits as well.
    localparam int DUTY_BITS = 16;

    localparam int CFG_BITS = 16;
    localparam int CMD_BITS = 32;
    localparam int SINCE_BITS = 17;

    localparam logic [CFG_BITS-1:0] MAX_DUTY_RESET = 16'd279;
    localparam logic [CFG_BITS-1:0] TIMEOUT_RESET = 16'd1000;
    localparam logic [CFG_BITS-1:0] REQUEST_INTERVAL_RESET = 16'd2000;

    typedef enum logic [1:0] {
        CFG_MAX_DUTY = 2'd0,
        CFG_TIMEOUT = 2'd1,
        CFG_REQUEST_INTERVAL = 2'd2
    } cfg_index_t;

    typedef enum logic [2:0] {
        OP_TICK = 3'd0,
        OP_PING = 3'd1,
        OP_JOY = 3'd2,
        OP_LAT = 3'd3,
        OP_STOP = 3'd4,
        OP_SHUT = 3'd5,
        OP_OTHER = 3'd6
    } opcode_t;

    typedef enum logic [2:0] {
        RC_NONE = 3'd0,
        RC_REQUEST = 3'd1,
        RC_PING = 3'd2,
        RC_JOY = 3'd3,
        RC_LAT = 3'd4,
        RC_INVALID = 3'd5
    } reply_t;

endpackage

// ===== design/motor_command_link_watchdog.sv =====
// Path: an accepted beat is registered in the input register and then moves into
//   the result register, where out_valid is raised and the result waits to be taken.
//   Output stalls hold the beat there and hold the input register behind it.
// Throughput: one beat per cycle while the output is not stalled; the link state
//   updates as a beat moves from the input register into the result register.
// Reset (rst_n low, asynchronous): link down, not halted, duties zero, direction
//   pins reverse, counters zero, registers at 279 / 1000 / 2000, both stages empty.
module motor_command_link_watchdog
(
    input  logic                                clk,
    input  logic                                rst_n,

    // configuration write port
    input  logic                                cfg_write,
    input  logic [1:0]                          cfg_index,
    input  logic [mcl_wdog_pkg::CFG_BITS-1:0]   cfg_data,

    // command / tick channel
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [2:0]                          opcode,
    input  logic signed [mcl_wdog_pkg::CMD_BITS-1:0] left_cmd,
    input  logic signed [mcl_wdog_pkg::CMD_BITS-1:0] right_cmd,

    // result channel
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [15:0]                         left_duty,
    output logic [15:0]                         right_duty,
    output logic                                left_forward,
    output logic                                right_forward,
    output logic [2:0]                          reply_code,
    output logic [2:0]                          echoed_tag,
    output logic                                link_up,
    output logic                                stopped_for_good
);
    import mcl_wdog_pkg::*;

    localparam logic [CMD_BITS:0] DUTY_MAX = (CMD_BITS+1)'((64'd1 << DUTY_BITS) - 64'd1);

    // Clamp one command to +/- lim and the duty width. Returns the magnitude;
    // a zero magnitude leaves the direction pin alone.
    function automatic logic [15:0] clamp_mag(input logic signed [CMD_BITS-1:0] cmd,
                                              input logic [CFG_BITS-1:0] lim);
        logic [CMD_BITS:0] mag;
        logic [CMD_BITS:0] lim_w;
        logic [CMD_BITS:0] capped;
        mag = cmd[CMD_BITS-1] ? ((CMD_BITS+1)'(0) - {1'b1, cmd})
                              : {1'b0, cmd};
        lim_w = (CMD_BITS+1)'(lim);
        capped = (mag > lim_w) ? lim_w : mag;
        if (capped > DUTY_MAX)
            capped = DUTY_MAX;
        return capped[15:0];
    endfunction

    // configuration
    logic [CFG_BITS-1:0] max_duty_reg;
    logic [CFG_BITS-1:0] timeout_reg;
    logic [CFG_BITS-1:0] interval_reg;

    // input stage
    logic                       in_full_reg;
    logic [2:0]                 op_reg;
    logic signed [CMD_BITS-1:0] left_cmd_reg;
    logic signed [CMD_BITS-1:0] right_cmd_reg;

    // link state
    logic                  connected_reg, connected_next;
    logic                  halted_reg, halted_next;
    logic                  left_dir_reg, left_dir_next;
    logic                  right_dir_reg, right_dir_next;
    logic [15:0]           left_cmp_reg, left_cmp_next;
    logic [15:0]           right_cmp_reg, right_cmp_next;
    logic [SINCE_BITS-1:0] since_ping_reg, since_ping_next;
    logic [15:0]           req_count_reg, req_count_next;

    // result stage
    logic       out_full_reg;
    logic [2:0] reply_reg, reply_next;
    logic [2:0] tag_reg, tag_next;

    logic advance;
    logic [15:0] left_mag, right_mag;
    logic [15:0] req_inc;
    logic [SINCE_BITS-1:0] since_inc;
    opcode_t op;

    // A beat moves on when the result stage is free or being taken; the input
    // stage can then refill in the same cycle.
    assign advance  = in_full_reg && (!out_full_reg || !out_stall);
    assign in_stall = in_full_reg && !advance;

    assign left_mag  = clamp_mag(left_cmd_reg, max_duty_reg);
    assign right_mag = clamp_mag(right_cmd_reg, max_duty_reg);
    assign req_inc   = req_count_reg + 16'd1;
    assign since_inc = (&since_ping_reg) ? since_ping_reg : since_ping_reg + 1'b1;

    always_comb
    begin
        case (op_reg)
            OP_TICK:  op = OP_TICK;
            OP_PING:  op = OP_PING;
            OP_JOY:   op = OP_JOY;
            OP_LAT:   op = OP_LAT;
            OP_STOP:  op = OP_STOP;
            OP_SHUT:  op = OP_SHUT;
            default:  op = OP_OTHER;   // unused code seven folds into other
        endcase
    end

    always_comb
    begin
        connected_next  = connected_reg;
        halted_next     = halted_reg;
        left_dir_next   = left_dir_reg;
        right_dir_next  = right_dir_reg;
        left_cmp_next   = left_cmp_reg;
        right_cmp_next  = right_cmp_reg;
        since_ping_next = since_ping_reg;
        req_count_next  = req_count_reg;
        reply_next      = RC_NONE;
        tag_next        = 3'd0;

        if (!halted_reg) begin
            if (!connected_reg) begin
                case (op)
                    OP_TICK:
                    begin
                        // zero interval requests on every tick
                        if (req_inc >= interval_reg) begin
                            req_count_next = 16'd0;
                            reply_next     = RC_REQUEST;
                        end
                        else begin
                            req_count_next = req_inc;
                        end
                    end
                    OP_PING:
                    begin
                        reply_next      = RC_PING;
                        connected_next  = 1'b1;
                        since_ping_next = '0;
                    end
                    default:
                    begin
                        reply_next = RC_INVALID;
                        tag_next   = op;
                    end
                endcase
            end
            else begin
                case (op)
                    OP_TICK:
                    begin
                        since_ping_next = since_inc;
                        if (since_inc > SINCE_BITS'(timeout_reg)) begin
                            connected_next = 1'b0;
                            left_cmp_next  = 16'd0;
                            right_cmp_next = 16'd0;
                            req_count_next = 16'd0;
                        end
                    end
                    OP_PING:
                    begin
                        reply_next      = RC_PING;
                        since_ping_next = '0;
                    end
                    OP_JOY:
                    begin
                        left_cmp_next  = left_mag;
                        right_cmp_next = right_mag;
                        if (left_mag != 16'd0)
                            left_dir_next = !left_cmd_reg[CMD_BITS-1];
                        if (right_mag != 16'd0)
                            right_dir_next = !right_cmd_reg[CMD_BITS-1];
                        reply_next = RC_JOY;
                    end
                    OP_LAT:
                    begin
                        reply_next = RC_LAT;
                    end
                    OP_STOP:
                    begin
                        left_cmp_next  = 16'd0;
                        right_cmp_next = 16'd0;
                    end
                    OP_SHUT:
                    begin
                        halted_next = 1'b1;
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            max_duty_reg <= MAX_DUTY_RESET;
            timeout_reg  <= TIMEOUT_RESET;
            interval_reg <= REQUEST_INTERVAL_RESET;
        end
        else if (cfg_write) begin
            case (cfg_index)
                CFG_MAX_DUTY:         max_duty_reg <= cfg_data;
                CFG_TIMEOUT:          timeout_reg  <= cfg_data;
                CFG_REQUEST_INTERVAL: interval_reg <= cfg_data;
                default:              ;   // no register there
            endcase
        end
    end

    // input stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_full_reg <= 1'b0;
        else if (!in_stall)
            in_full_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall) begin
            op_reg        <= opcode;
            left_cmd_reg  <= left_cmd;
            right_cmd_reg <= right_cmd;
        end
    end

    // link state and result stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            connected_reg  <= 1'b0;
            halted_reg     <= 1'b0;
            left_dir_reg   <= 1'b0;
            right_dir_reg  <= 1'b0;
            left_cmp_reg   <= 16'd0;
            right_cmp_reg  <= 16'd0;
            since_ping_reg <= '0;
            req_count_reg  <= 16'd0;
            out_full_reg   <= 1'b0;
        end
        else begin
            if (advance) begin
                connected_reg  <= connected_next;
                halted_reg     <= halted_next;
                left_dir_reg   <= left_dir_next;
                right_dir_reg  <= right_dir_next;
                left_cmp_reg   <= left_cmp_next;
                right_cmp_reg  <= right_cmp_next;
                since_ping_reg <= since_ping_next;
                req_count_reg  <= req_count_next;
            end
            if (advance)
                out_full_reg <= 1'b1;
            else if (!out_stall)
                out_full_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance) begin
            reply_reg <= reply_next;
            tag_reg   <= tag_next;
        end
    end

    // The state registers only move with a beat, so they double as the
    // result payload for the beat sitting in the result stage.
    assign out_valid        = out_full_reg;
    assign left_duty        = left_cmp_reg;
    assign right_duty       = right_cmp_reg;
    assign left_forward     = left_dir_reg;
    assign right_forward    = right_dir_reg;
    assign reply_code       = reply_reg;
    assign echoed_tag       = tag_reg;
    assign link_up          = connected_reg;
    assign stopped_for_good = halted_reg;

endmodule
